// ----- rtl/core/bfr_pkg.sv -----
// ----------------------------------------------------------------------------
// bfr_pkg
// Shared types, constants and helpers of the bitmap font text renderer.
// ----------------------------------------------------------------------------
package bfr_pkg;

  // Build-time defaults for the top level parameters.
  localparam int unsigned GlyphStoreDepth = 4096;
  localparam int unsigned MaxGlyphHeight  = 16;

  // Field widths fixed by the interface.
  localparam int unsigned AddrW   = 48;
  localparam int unsigned ColorW  = 32;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgW    = 48;

  // Character codes with a special meaning.
  localparam logic [7:0] CodeCr = 8'd13;
  localparam logic [7:0] CodeLf = 8'd10;

  // Kind of an input beat.
  localparam logic KindLoad  = 1'b0;
  localparam logic KindPrint = 1'b1;

  // Configuration register indexes.
  typedef enum logic [CfgIdxW-1:0] {
    CFG_GLYPH_HEIGHT  = 3'd0,
    CFG_SCREEN_WIDTH  = 3'd1,
    CFG_SCREEN_HEIGHT = 3'd2,
    CFG_LINE_PITCH    = 3'd3,
    CFG_FRAME_BASE    = 3'd4
  } cfg_idx_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECIDE,
    S_MUL,
    S_ADDR,
    S_ROWS
  } state_e;

  // Left-aligned mask of w set pixels, bit 7 being the leftmost one.
  function automatic logic [7:0] glyph_mask(input logic [3:0] w);
    glyph_mask = ~(8'hFF >> w);
  endfunction

endpackage

// ----- rtl/core/bfr_ram.sv -----
// ----------------------------------------------------------------------------
// bfr_ram
// Generic simple dual-port RAM: one write port, one read port with a
// registered read that only updates when a read is enabled.
// ----------------------------------------------------------------------------
module bfr_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4096,
  localparam int unsigned AW   = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/core/bitmap_font_text_renderer.sv -----
// ----------------------------------------------------------------------------
// bitmap_font_text_renderer
// Text console renderer: glyph rows live in an on-chip glyph store, and each
// drawn character becomes one framebuffer row write per glyph row.
// ----------------------------------------------------------------------------
//
//  Channel  | Direction | Handshake           | Payload
//  ---------+-----------+---------------------+----------------------------------
//  in       | sink      | in_valid/in_ready   | kind, glyph_index, glyph_byte,
//           |           |                     | char_code, color
//  out      | source    | out_valid/out_ready | row_address, pixel_mask,
//           |           |                     | pixel_color, last
//  cfg      | sink      | cfg_we (no wait)    | cfg_index, cfg_wdata
//
// A load beat writes the glyph store directly when it is accepted.
// A carriage return or line feed only moves the cursor in the decide step.
// A drawn character goes through three setup steps (decide, multiply y by
// the pitch, form the start address) and then reads one glyph row per cycle
// while the output does not stall, h rows in all, with h the glyph height;
// the single read port of the glyph store sets the row rate.
// The next beat is taken once the last row read has been issued, while that
// row and the one before it still drain through the output register.
// A stalled output holds the read data in the glyph store's read register.
// Reset restores the register defaults and homes the cursor; the glyph
// store has no reset and holds garbage until it is loaded.
// ----------------------------------------------------------------------------
module bitmap_font_text_renderer
  import bfr_pkg::*;
#(
  parameter int unsigned GLYPH_STORE_DEPTH = GlyphStoreDepth,
  parameter int unsigned MAX_GLYPH_HEIGHT  = MaxGlyphHeight
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // Configuration write port
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [CfgW-1:0]    cfg_wdata_i,
  // Input channel
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               kind_i,
  input  logic [11:0]        glyph_index_i,
  input  logic [7:0]         glyph_byte_i,
  input  logic [7:0]         char_code_i,
  input  logic [ColorW-1:0]  color_i,
  // Output channel
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [AddrW-1:0]   row_address_o,
  output logic [7:0]         pixel_mask_o,
  output logic [ColorW-1:0]  pixel_color_o,
  output logic               last_o
);

  localparam int unsigned AW = $clog2(GLYPH_STORE_DEPTH);
  // Wide enough for every glyph index and for the store depth itself.
  localparam int unsigned IW = 14;

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [4:0]       glyph_height_q;
  logic [12:0]      screen_width_q;
  logic [12:0]      screen_height_q;
  logic [13:0]      line_pitch_q;
  logic [AddrW-1:0] frame_base_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      glyph_height_q  <= 5'd16;
      screen_width_q  <= 13'd640;
      screen_height_q <= 13'd480;
      line_pitch_q    <= 14'd640;
      frame_base_q    <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_GLYPH_HEIGHT:  glyph_height_q  <= cfg_wdata_i[4:0];
        CFG_SCREEN_WIDTH:  screen_width_q  <= cfg_wdata_i[12:0];
        CFG_SCREEN_HEIGHT: screen_height_q <= cfg_wdata_i[12:0];
        CFG_LINE_PITCH:    line_pitch_q    <= cfg_wdata_i[13:0];
        CFG_FRAME_BASE:    frame_base_q    <= cfg_wdata_i[AddrW-1:0];
        default: ;
      endcase
    end
  end

  // Effective glyph height is clamped to the largest supported font, and
  // the glyph width is half of it.
  logic [4:0] h_eff;
  logic [3:0] w_eff;
  logic [7:0] width_mask;

  assign h_eff      = (glyph_height_q > 5'(MAX_GLYPH_HEIGHT)) ? 5'(MAX_GLYPH_HEIGHT)
                                                              : glyph_height_q;
  assign w_eff      = h_eff[4:1];
  assign width_mask = glyph_mask(w_eff);

  // --------------------------------------------------------------------------
  // Control and datapath registers
  // --------------------------------------------------------------------------
  state_e             state_q, state_d;
  logic [12:0]        cursor_x_q, cursor_x_d;
  logic [15:0]        cursor_y_q, cursor_y_d;
  logic [7:0]         code_q;
  logic [ColorW-1:0]  color_q;
  logic [29:0]        prod_q;
  logic [AddrW-1:0]   row_addr_q;
  logic [IW-1:0]      idx_q;
  logic [4:0]         row_cnt_q;

  // Row currently held in the glyph store read register.
  logic               rd_vld_q;
  logic [AddrW-1:0]   rd_addr_q;
  logic [ColorW-1:0]  rd_color_q;
  logic               rd_last_q;
  logic               rd_oob_q;

  // Output register.
  logic               out_vld_q;
  logic [AddrW-1:0]   out_addr_q;
  logic [7:0]         out_mask_q;
  logic [ColorW-1:0]  out_color_q;
  logic               out_last_q;

  logic               in_acc;
  logic               move;
  logic               issue;
  logic               row_last;

  // Cursor arithmetic of the decide step.
  logic [13:0]        x_plus_w;
  logic               wrap;
  logic [16:0]        y_lf;
  logic [15:0]        y_sat;
  logic [15:0]        y_eff;
  logic [16:0]        y_bottom;
  logic               draw;

  // Glyph store ports.
  logic [IW-1:0]      load_idx;
  logic               ram_we;
  logic [7:0]         ram_rdata;

  logic [30:0]        pix;
  logic [AddrW-1:0]   pitch_bytes;

  assign in_acc = in_valid_i && in_ready_o;

  assign x_plus_w = {1'b0, cursor_x_q} + {10'd0, w_eff};
  assign wrap     = x_plus_w > {1'b0, screen_width_q};
  assign y_lf     = {1'b0, cursor_y_q} + {12'd0, h_eff};
  assign y_sat    = y_lf[16] ? 16'hFFFF : y_lf[15:0];
  assign y_eff    = wrap ? y_sat : cursor_y_q;
  assign y_bottom = {1'b0, y_eff} + {12'd0, h_eff};
  assign draw     = y_bottom < {4'd0, screen_height_q};

  // The read register of the glyph store doubles as a skid stage: a new row is
  // read only when it is empty or the previous one leaves for the output register.
  assign move     = rd_vld_q && (!out_vld_q || out_ready_i);
  assign row_last = (row_cnt_q == (h_eff - 5'd1));

  assign pix         = {1'b0, prod_q} + {18'd0, cursor_x_q};
  assign pitch_bytes = {{(AddrW-16){1'b0}}, line_pitch_q, 2'b00};

  always_comb begin
    state_d    = state_q;
    cursor_x_d = cursor_x_q;
    cursor_y_d = cursor_y_q;
    issue      = 1'b0;
    in_ready_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i && (kind_i == KindPrint)) begin
          state_d = S_DECIDE;
        end
      end
      S_DECIDE: begin
        state_d = S_IDLE;
        if (code_q == CodeCr) begin
          cursor_x_d = '0;
        end else if (code_q == CodeLf) begin
          cursor_y_d = y_sat;
        end else begin
          if (wrap) begin
            cursor_x_d = '0;
          end
          cursor_y_d = y_eff;
          if (draw) begin
            state_d = S_MUL;
          end
        end
      end
      S_MUL: begin
        state_d = S_ADDR;
      end
      S_ADDR: begin
        cursor_x_d = cursor_x_q + {9'd0, w_eff};
        state_d    = (h_eff == 5'd0) ? S_IDLE : S_ROWS;
      end
      S_ROWS: begin
        issue = !rd_vld_q || move;
        if (issue && row_last) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      cursor_x_q <= '0;
      cursor_y_q <= '0;
      rd_vld_q   <= 1'b0;
      out_vld_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      cursor_x_q <= cursor_x_d;
      cursor_y_q <= cursor_y_d;
      rd_vld_q   <= issue || (rd_vld_q && !move);
      if (move) begin
        out_vld_q <= 1'b1;
      end else if (out_ready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc && (kind_i == KindPrint)) begin
      code_q  <= char_code_i;
      color_q <= color_i;
    end
    if (state_q == S_MUL) begin
      prod_q <= cursor_y_q * line_pitch_q;
    end
    if (state_q == S_ADDR) begin
      row_addr_q <= frame_base_q + {{(AddrW-33){1'b0}}, pix, 2'b00};
      idx_q      <= {6'd0, code_q} * {9'd0, h_eff};
      row_cnt_q  <= '0;
    end
    if (issue) begin
      row_addr_q <= row_addr_q + pitch_bytes;
      idx_q      <= idx_q + IW'(1);
      row_cnt_q  <= row_cnt_q + 5'd1;
      rd_addr_q  <= row_addr_q;
      rd_color_q <= color_q;
      rd_last_q  <= row_last;
      rd_oob_q   <= idx_q >= IW'(GLYPH_STORE_DEPTH);
    end
    if (move) begin
      out_addr_q  <= rd_addr_q;
      out_mask_q  <= rd_oob_q ? 8'd0 : (ram_rdata & width_mask);
      out_color_q <= rd_color_q;
      out_last_q  <= rd_last_q;
    end
  end

  // --------------------------------------------------------------------------
  // Glyph store
  // --------------------------------------------------------------------------
  assign load_idx = {2'b00, glyph_index_i};
  assign ram_we   = in_acc && (kind_i == KindLoad) && (load_idx < IW'(GLYPH_STORE_DEPTH));

  bfr_ram #(
    .WIDTH (8),
    .DEPTH (GLYPH_STORE_DEPTH)
  ) u_glyph_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (load_idx[AW-1:0]),
    .wdata_i (glyph_byte_i),
    .re_i    (issue),
    .raddr_i (idx_q[AW-1:0]),
    .rdata_o (ram_rdata)
  );

  assign out_valid_o   = out_vld_q;
  assign row_address_o = out_addr_q;
  assign pixel_mask_o  = out_mask_q;
  assign pixel_color_o = out_color_q;
  assign last_o        = out_last_q;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  // A row that is not the last one of its glyph is always followed by another
  // row, either already read or still to be read.
  a_rows_follow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_ready_i && !last_o) |-> (rd_vld_q || state_q == S_ROWS))
    else $error("glyph row stream ended without a last row");

  // The read register only fills from a row read of the drawing phase.
  a_read_origin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rd_vld_q) |-> $past(state_q) == S_ROWS)
    else $error("glyph store read outside the row phase");

  // The row counter never passes the effective glyph height.
  a_row_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_ROWS) |-> (row_cnt_q < h_eff))
    else $error("row counter beyond glyph height");

endmodule
